// File: sv/dspl_pkg.sv
// ---------------------------------------------------------------------------
// dual sorted priority list package
// shared types, codes and defaults for the sorted list cell chain
// ---------------------------------------------------------------------------
package dspl_pkg;

   localparam int LIST_DEPTH_DEF  = 16;
   localparam int HANDLE_BITS_DEF = 8;

   // request mode codes
   localparam logic [2:0] MODE_ADD       = 3'd0;
   localparam logic [2:0] MODE_REMOVE    = 3'd1;
   localparam logic [2:0] MODE_CHANGE    = 3'd2;
   localparam logic [2:0] MODE_CLEAR     = 3'd3;
   localparam logic [2:0] MODE_READ_PUMP = 3'd4;
   localparam logic [2:0] MODE_READ_DRAW = 3'd5;

   // response status codes
   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_FULL      = 2'd1;
   localparam logic [1:0] STATUS_NOT_FOUND = 2'd2;
   localparam logic [1:0] STATUS_RANGE     = 2'd3;

   typedef struct packed {
      logic [2:0]         mode;
      logic [7:0]         handle;
      logic signed [31:0] pump_priority;
      logic signed [31:0] draw_priority;
      logic [3:0]         position;
   } req_type;

   typedef struct packed {
      logic [1:0]         status;
      logic [7:0]         read_handle;
      logic signed [31:0] read_priority;
      logic [4:0]         entry_count;
   } rsp_type;

   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_FIND,
      CELL_DELETE,
      CELL_INSERT
   } cell_op_type;

   typedef struct packed {
      cell_op_type        op;
      logic signed [31:0] key_prio;
   } cell_ctl_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FIND,
      ST_DELETE,
      ST_INSERT,
      ST_READ,
      ST_DONE
   } state_type;

endpackage

// File: sv/dspl_cell.sv
// ---------------------------------------------------------------------------
// sorted list cell
// holds one list entry; matches, shifts left on delete, shifts right on insert
// ---------------------------------------------------------------------------
module dspl_cell #(
   parameter int HANDLE_BITS = dspl_pkg::HANDLE_BITS_DEF
) (
   input  logic                     clock,
   input  dspl_pkg::cell_ctl_type   ctl,
   input  logic [HANDLE_BITS-1:0]   key_handle,
   input  logic                     live,
   input  logic                     left_keep,
   input  logic                     shift,
   input  logic [HANDLE_BITS-1:0]   left_handle,
   input  logic signed [31:0]       left_prio,
   input  logic [HANDLE_BITS-1:0]   right_handle,
   input  logic signed [31:0]       right_prio,
   output logic                     keep,
   output logic                     match,
   output logic [HANDLE_BITS-1:0]   handle,
   output logic signed [31:0]       prio
);
   import dspl_pkg::*;

   logic [HANDLE_BITS-1:0] handle_ff, handle_in;
   logic signed [31:0]     prio_ff, prio_in;
   logic                   match_ff, match_in;

   // entry stays put on insert when it outranks the new one
   assign keep = live && (prio_ff > ctl.key_prio);

   always_comb begin
      handle_in = handle_ff;
      prio_in   = prio_ff;
      match_in  = match_ff;
      case (ctl.op)
         CELL_FIND: begin
            match_in = live && (handle_ff == key_handle);
         end
         CELL_DELETE: begin
            if (shift) begin
               handle_in = right_handle;
               prio_in   = right_prio;
            end
         end
         CELL_INSERT: begin
            if (!keep) begin
               if (left_keep) begin
                  handle_in = key_handle;
                  prio_in   = ctl.key_prio;
               end else begin
                  handle_in = left_handle;
                  prio_in   = left_prio;
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      handle_ff <= handle_in;
      prio_ff   <= prio_in;
      match_ff  <= match_in;
   end

   assign match  = match_ff;
   assign handle = handle_ff;
   assign prio   = prio_ff;

endmodule

// File: sv/dspl_chain.sv
// ---------------------------------------------------------------------------
// sorted list cell chain
// one descending list as a row of cells, with first-match and read select
// ---------------------------------------------------------------------------
module dspl_chain #(
   parameter int LIST_DEPTH  = dspl_pkg::LIST_DEPTH_DEF,
   parameter int HANDLE_BITS = dspl_pkg::HANDLE_BITS_DEF,
   localparam int CNT_W      = $clog2(LIST_DEPTH + 1),
   localparam int IDX_W      = $clog2(LIST_DEPTH)
) (
   input  logic                     clock,
   input  dspl_pkg::cell_ctl_type   ctl,
   input  logic [HANDLE_BITS-1:0]   key_handle,
   input  logic [CNT_W-1:0]         count,
   input  logic [3:0]               read_pos,
   output logic                     found,
   output logic [HANDLE_BITS-1:0]   rd_handle,
   output logic signed [31:0]       rd_prio
);
   import dspl_pkg::*;

   logic [LIST_DEPTH-1:0]  keep_q;
   logic [LIST_DEPTH-1:0]  match_q;
   logic [LIST_DEPTH-1:0]  first_hit;
   logic [LIST_DEPTH-1:0]  shift_mask;
   logic [HANDLE_BITS-1:0] handle_q [LIST_DEPTH];
   logic signed [31:0]     prio_q   [LIST_DEPTH];
   logic [IDX_W+3:0]       pos_wide;
   logic [IDX_W-1:0]       rd_idx;

   // isolate the first match, everything at or after it moves left
   assign first_hit  = match_q & (~match_q + LIST_DEPTH'(1));
   assign shift_mask = ~(first_hit - LIST_DEPTH'(1));
   assign found      = |match_q;

   for (genvar i = 0; i < LIST_DEPTH; i++) begin : g_cell
      logic                   live;
      logic                   left_keep;
      logic [HANDLE_BITS-1:0] left_handle;
      logic signed [31:0]     left_prio;
      logic [HANDLE_BITS-1:0] right_handle;
      logic signed [31:0]     right_prio;

      assign live = (CNT_W'(i) < count);

      if (i == 0) begin : g_head
         assign left_keep   = 1'b1;
         assign left_handle = key_handle;
         assign left_prio   = ctl.key_prio;
      end else begin : g_body
         assign left_keep   = keep_q[i-1];
         assign left_handle = handle_q[i-1];
         assign left_prio   = prio_q[i-1];
      end

      if (i == LIST_DEPTH - 1) begin : g_tail
         assign right_handle = handle_q[i];
         assign right_prio   = prio_q[i];
      end else begin : g_mid
         assign right_handle = handle_q[i+1];
         assign right_prio   = prio_q[i+1];
      end

      dspl_cell #(
         .HANDLE_BITS (HANDLE_BITS)
      ) u_cell (
         .clock        (clock),
         .ctl          (ctl),
         .key_handle   (key_handle),
         .live         (live),
         .left_keep    (left_keep),
         .shift        (shift_mask[i]),
         .left_handle  (left_handle),
         .left_prio    (left_prio),
         .right_handle (right_handle),
         .right_prio   (right_prio),
         .keep         (keep_q[i]),
         .match        (match_q[i]),
         .handle       (handle_q[i]),
         .prio         (prio_q[i])
      );
   end

   // read select, only meaningful below count
   assign pos_wide  = {IDX_W'(0), read_pos};
   assign rd_idx    = pos_wide[IDX_W-1:0];
   assign rd_handle = handle_q[rd_idx];
   assign rd_prio   = prio_q[rd_idx];

endmodule

// File: sv/dual_sorted_priority_list_unit.sv
// ---------------------------------------------------------------------------
// dual sorted priority list unit
// two descending priority lists of the same handles kept in cell chains
// ---------------------------------------------------------------------------
// Holds up to LIST_DEPTH handles in two lists, one sorted by pump priority and
// one by draw priority, largest first; a new entry lands ahead of older
// entries of equal priority. Each list is a row of cells that all compare
// against the request at once and shift by one place toward a neighbor, so a
// request walks a short sequencer: accept, find, shift or read, respond.
// Change priority does a delete shift then an insert shift; remove-all,
// unused modes, an add dropped on a full list and a read past the count
// skip the shift. One request is in flight at a time; a finished response
// sits in an output register so the next request is accepted while it
// waits to be taken. A full list drops the add with status full, a missing
// handle gives not found, and a read at or past the count gives out of
// range with zero data.
// ---------------------------------------------------------------------------
module dual_sorted_priority_list_unit #(
   parameter int LIST_DEPTH  = dspl_pkg::LIST_DEPTH_DEF,
   parameter int HANDLE_BITS = dspl_pkg::HANDLE_BITS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  dspl_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output dspl_pkg::rsp_type rsp_data
);
   import dspl_pkg::*;

   localparam int CNT_W = $clog2(LIST_DEPTH + 1);

   state_type              state_ff, state_in;
   req_type                req_ff;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic [1:0]             status_ff, status_in;
   logic [7:0]             rd_handle_ff, rd_handle_in;
   logic signed [31:0]     rd_prio_ff, rd_prio_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_type                rsp_ff, rsp_in;

   cell_op_type            cell_op;
   cell_ctl_type           pump_ctl, draw_ctl;
   logic [HANDLE_BITS+7:0] key_wide;
   logic [HANDLE_BITS-1:0] key_handle;
   logic                   pump_found, draw_found, found;
   logic [HANDLE_BITS-1:0] pump_rd_handle, draw_rd_handle, sel_handle;
   logic signed [31:0]     pump_rd_prio, draw_rd_prio;
   logic [HANDLE_BITS+7:0] sel_wide;
   logic [CNT_W+4:0]       count_wide;
   logic [CNT_W+3:0]       pos_cmp, cnt_cmp;
   logic                   full, out_of_range, rsp_free;

   // handle masked to the stored width
   assign key_wide   = {HANDLE_BITS'(0), req_ff.handle};
   assign key_handle = key_wide[HANDLE_BITS-1:0];

   assign full         = (count_ff == CNT_W'(LIST_DEPTH));
   assign pos_cmp      = {CNT_W'(0), req_ff.position};
   assign cnt_cmp      = {4'd0, count_ff};
   assign out_of_range = (pos_cmp >= cnt_cmp);
   assign found        = pump_found && draw_found;
   assign rsp_free     = !rsp_valid_ff || rsp_ready;

   // per-list cell control, same op with each list's own key
   assign pump_ctl = '{op: cell_op, key_prio: req_ff.pump_priority};
   assign draw_ctl = '{op: cell_op, key_prio: req_ff.draw_priority};

   dspl_chain #(
      .LIST_DEPTH  (LIST_DEPTH),
      .HANDLE_BITS (HANDLE_BITS)
   ) u_pump (
      .clock      (clock),
      .ctl        (pump_ctl),
      .key_handle (key_handle),
      .count      (count_ff),
      .read_pos   (req_ff.position),
      .found      (pump_found),
      .rd_handle  (pump_rd_handle),
      .rd_prio    (pump_rd_prio)
   );

   dspl_chain #(
      .LIST_DEPTH  (LIST_DEPTH),
      .HANDLE_BITS (HANDLE_BITS)
   ) u_draw (
      .clock      (clock),
      .ctl        (draw_ctl),
      .key_handle (key_handle),
      .count      (count_ff),
      .read_pos   (req_ff.position),
      .found      (draw_found),
      .rd_handle  (draw_rd_handle),
      .rd_prio    (draw_rd_prio)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_FIND;
         end
         ST_FIND: begin
            case (req_ff.mode)
               MODE_ADD:                   state_in = full ? ST_DONE : ST_INSERT;
               MODE_REMOVE, MODE_CHANGE:   state_in = ST_DELETE;
               MODE_READ_PUMP,
               MODE_READ_DRAW:             state_in = out_of_range ? ST_DONE : ST_READ;
               default:                    state_in = ST_DONE;
            endcase
         end
         ST_DELETE: begin
            // change re-inserts after the delete shift
            if (found && (req_ff.mode == MODE_CHANGE)) state_in = ST_INSERT;
            else state_in = ST_DONE;
         end
         ST_INSERT: state_in = ST_DONE;
         ST_READ:   state_in = ST_DONE;
         ST_DONE: begin
            if (rsp_free) state_in = ST_IDLE;
         end
         default:   state_in = ST_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      req_ready = 1'b0;
      cell_op   = CELL_HOLD;
      unique case (state_ff)
         ST_IDLE:   req_ready = 1'b1;
         ST_FIND:   cell_op   = CELL_FIND;
         ST_DELETE: cell_op   = found ? CELL_DELETE : CELL_HOLD;
         ST_INSERT: cell_op   = CELL_INSERT;
         default: begin
         end
      endcase
   end

   // count, status and read data updates
   assign sel_handle = (req_ff.mode == MODE_READ_PUMP) ? pump_rd_handle : draw_rd_handle;
   assign sel_wide   = {8'd0, sel_handle};
   assign count_wide = {5'd0, count_ff};

   always_comb begin
      count_in     = count_ff;
      status_in    = status_ff;
      rd_handle_in = rd_handle_ff;
      rd_prio_in   = rd_prio_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      case (state_ff)
         ST_FIND: begin
            status_in    = STATUS_OK;
            rd_handle_in = '0;
            rd_prio_in   = '0;
            if ((req_ff.mode == MODE_ADD) && full) status_in = STATUS_FULL;
            if (((req_ff.mode == MODE_READ_PUMP) || (req_ff.mode == MODE_READ_DRAW))
                && out_of_range) status_in = STATUS_RANGE;
            if (req_ff.mode == MODE_CLEAR) count_in = '0;
         end
         ST_DELETE: begin
            if (found) count_in = count_ff - CNT_W'(1);
            else status_in = STATUS_NOT_FOUND;
         end
         ST_INSERT: begin
            count_in = count_ff + CNT_W'(1);
         end
         ST_READ: begin
            rd_handle_in = sel_wide[7:0];
            rd_prio_in   = (req_ff.mode == MODE_READ_PUMP) ? pump_rd_prio : draw_rd_prio;
         end
         ST_DONE: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_in       = '{status:        status_ff,
                                read_handle:   rd_handle_ff,
                                read_priority: rd_prio_ff,
                                entry_count:   count_wide[4:0]};
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) req_ff <= req_data;
      status_ff    <= status_in;
      rd_handle_ff <= rd_handle_in;
      rd_prio_ff   <= rd_prio_in;
      rsp_ff       <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // count never runs past the list depth
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(LIST_DEPTH))
      else $error("entry count above list depth");

   // an insert shift only happens with room for the entry
   a_insert_room: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_INSERT) |-> !full)
      else $error("insert into a full list");

   // both lists hold the same handles, so lookups agree
   a_lists_agree: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DELETE) |-> (pump_found == draw_found))
      else $error("pump and draw lists disagree on handle");

   // an accepted request starts the find step
   a_accept_find: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == ST_FIND))
      else $error("accepted request did not start lookup");

endmodule
